// ===== sv/tween_easing_scheduler_unit_defines.svh =====
// Assertion macros for the tween easing scheduler.
// Used by tween_easing_scheduler_unit.sv; needs clk and rst_n in scope.
`ifndef TWEEN_EASING_SCHEDULER_UNIT_DEFINES_SVH
`define TWEEN_EASING_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tes_pkg.sv =====
// Shared types and constants of the tween easing scheduler.
// No dependencies.
package tes_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EASE_LINEAR  = 2'd0,
        EASE_OUT     = 2'd1,
        EASE_INOUT   = 2'd2,
        EASE_INOUT_B = 2'd3
    } ease_t;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam int          FRAC_BITS = 16;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        now_time;
        logic [31:0]        cancel_handle;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [31:0]        duration_time;
        logic [1:0]         easing_mode;
        logic               repeat_enable;
        logic               pingpong_enable;
    } req_t;

    typedef struct packed {
        logic [31:0]        tween_handle;
        logic signed [31:0] tween_value;
        logic               value_valid;
        logic               finished;
        logic               table_full;
        logic               last_result;
    } rsp_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] sv;
        logic [31:0] ev;
        logic [31:0] dur;
        logic [1:0]  mode;
        logic        rep;
        logic        ping;
        logic        fwd;
        logic        started;
    } slot_t;

endpackage

// ===== sv/tween_easing_scheduler_unit.sv =====
// Tween easing scheduler: tween table, shared divider/multiplier sequencer and
// output register. Depends on tes_pkg and tween_easing_scheduler_unit_defines.svh.
//
// Sequence: a start request loads its response and emits it; a clear is done in
// idle. A cancel with a nonzero handle on a non-empty table compacts the
// survivors, one slot compacted per cycle. A tick walks the tweens in start order,
// one at a time, and gives one response each: an ended tween goes from load
// straight to emit; a running one is loaded, its progress found by restoring
// division, then square, cube, ease, blend, sum and emit follow (linear easing
// skips cube and ease). The block stalls requests until the last response of
// the current one sits in the output register; a stalled output stalls the walk.
// Values are signed Q16.16, progress is Q0.16, and elapsed time wraps modulo
// 2^TIME_WIDTH.
`include "tween_easing_scheduler_unit_defines.svh"

module tween_easing_scheduler_unit
    import tes_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int TIME_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int DW    = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOAD   = 10'b0000000010,
        S_DIV    = 10'b0000000100,
        S_SQ     = 10'b0000001000,
        S_CUBE   = 10'b0000010000,
        S_EASE   = 10'b0000100000,
        S_BLEND  = 10'b0001000000,
        S_SUM    = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_CANCEL = 10'b1000000000
    } state_t;

    // Tween table
    slot_t                 slot_mem [NUM_SLOTS];
    logic [TIME_WIDTH-1:0] begin_mem [NUM_SLOTS];

    state_t                state_reg;
    logic [CNT_W-1:0]      active_reg;
    logic [31:0]           next_handle_reg;
    logic [CNT_W-1:0]      rd_reg;       // slot being read
    logic [CNT_W-1:0]      wr_reg;       // compaction write slot
    logic                  tick_reg;     // current request is a tick
    logic [31:0]           cancel_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    // Working copy of the tween being ticked
    slot_t                 work_reg;
    logic [TIME_WIDTH-1:0] begin_reg;
    logic                  keep_reg;
    logic signed [31:0]    from_reg;
    logic signed [31:0]    to_reg;
    logic [DW:0]           rem_reg;
    logic [15:0]           q_reg;
    logic [3:0]            div_cnt_reg;
    logic [16:0]           base_reg;
    logic [33:0]           sq_reg;
    logic [50:0]           cube_reg;
    logic [16:0]           e_reg;
    logic signed [50:0]    prod_reg;
    rsp_t                  res_reg;

    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    // Read side of the table
    slot_t                 rd_slot;
    logic [TIME_WIDTH-1:0] rd_begin;
    logic [TIME_WIDTH-1:0] begin_eff;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [DW-1:0]         el_ext;
    logic [DW-1:0]         dur_ext;
    logic [DW:0]           rem_dbl;
    logic                  out_free;
    logic [16:0]           base_sel;
    logic [51:0]           ease_sum;
    logic signed [34:0]    blend_q;
    logic                  start_full;
    rsp_t                  start_rsp;
    logic                  load_ended;
    slot_t                 load_slot;
    rsp_t                  load_rsp;

    assign rd_slot   = slot_mem[rd_reg[IDX_W-1:0]];
    assign rd_begin  = begin_mem[rd_reg[IDX_W-1:0]];
    assign begin_eff = rd_slot.started ? rd_begin : now_reg;
    assign elapsed   = now_reg - begin_eff;
    assign el_ext    = DW'(elapsed);
    assign dur_ext   = DW'(rd_slot.dur);
    assign rem_dbl   = {rem_reg[DW-1:0], 1'b0};
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign start_full = (active_reg >= CNT_W'(NUM_SLOTS));
    assign load_ended = (el_ext >= dur_ext);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Response to a start: new handle, or full flag with handle zero
    always_comb
    begin
        start_rsp = '0;
        start_rsp.last_result = 1'b1;
        if (start_full)
            start_rsp.table_full = 1'b1;
        else
            start_rsp.tween_handle = next_handle_reg;
    end

    // Slot as written back after this tick: started, direction flipped on a
    // pingpong restart
    always_comb
    begin
        load_slot = rd_slot;
        load_slot.started = 1'b1;
        if (load_ended && rd_slot.rep && rd_slot.ping)
            load_slot.fwd = !rd_slot.fwd;
    end

    // Response skeleton for the slot being loaded; an ended tween gives its endpoint
    always_comb
    begin
        load_rsp = '0;
        load_rsp.tween_handle = rd_slot.handle;
        load_rsp.value_valid  = 1'b1;
        load_rsp.last_result  = (rd_reg == active_reg - 1'b1);
        if (load_ended)
        begin
            load_rsp.tween_value = rd_slot.fwd ? rd_slot.ev : rd_slot.sv;
            load_rsp.finished    = !rd_slot.rep;
        end
    end

    // Cube base per easing curve
    always_comb
    begin
        case (ease_t'(work_reg.mode))
            EASE_OUT:
                base_sel = ONE_Q16 - {1'b0, q_reg};
            default:
                if (!q_reg[15])
                    base_sel = {1'b0, q_reg};
                else
                    base_sel = {(ONE_Q16[15:0] - q_reg), 1'b0};
        endcase
    end

    // Round and fold the cube back into eased progress
    always_comb
    begin
        case (ease_t'(work_reg.mode))
            EASE_OUT:
                ease_sum = ({1'b0, cube_reg} + (52'd1 << 31)) >> 32;
            default:
                if (!q_reg[15])
                    ease_sum = ({1'b0, cube_reg} + (52'd1 << 29)) >> 30;
                else
                    ease_sum = ({1'b0, cube_reg} + (52'd1 << 32)) >> 33;
        endcase
    end

    assign blend_q = 35'((prod_reg + 51'sd32768) >>> FRAC_BITS);

    // Table writes: no reset, entries past the active count are never read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid && op_t'(req_data.operation) == OP_START
            && !start_full)
        begin
            slot_mem[active_reg[IDX_W-1:0]] <= '{
                handle:  next_handle_reg,
                sv:      req_data.start_value,
                ev:      req_data.end_value,
                dur:     (req_data.duration_time == 32'd0) ? 32'd1 : req_data.duration_time,
                mode:    req_data.easing_mode,
                rep:     req_data.repeat_enable,
                ping:    req_data.pingpong_enable,
                fwd:     1'b1,
                started: 1'b0
            };
            begin_mem[active_reg[IDX_W-1:0]] <= '0;
        end
        else if (state_reg == S_CANCEL && rd_reg < active_reg
                 && rd_slot.handle != cancel_reg)
        begin
            slot_mem[wr_reg[IDX_W-1:0]]  <= rd_slot;
            begin_mem[wr_reg[IDX_W-1:0]] <= rd_begin;
        end
        else if (state_reg == S_EMIT && tick_reg && out_free && keep_reg)
        begin
            slot_mem[wr_reg[IDX_W-1:0]]  <= work_reg;
            begin_mem[wr_reg[IDX_W-1:0]] <= begin_reg;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_reg      <= '0;
            next_handle_reg <= 32'd1;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            // Load the output register on emit, drop it once taken
            if (state_reg == S_EMIT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        now_reg    <= TIME_WIDTH'(req_data.now_time);
                        cancel_reg <= req_data.cancel_handle;
                        rd_reg     <= '0;
                        wr_reg     <= '0;
                        tick_reg   <= (op_t'(req_data.operation) == OP_TICK);
                        case (op_t'(req_data.operation))
                            OP_START:
                            begin
                                res_reg <= start_rsp;
                                if (!start_full)
                                begin
                                    active_reg <= active_reg + 1'b1;
                                    next_handle_reg <= (next_handle_reg == 32'hFFFF_FFFF)
                                                       ? 32'd1 : next_handle_reg + 32'd1;
                                end
                                state_reg <= S_EMIT;
                            end
                            OP_CANCEL:
                            begin
                                if (req_data.cancel_handle != 32'd0 && active_reg != '0)
                                begin
                                    state_reg <= S_CANCEL;
                                end
                            end
                            OP_CLEAR:
                            begin
                                active_reg <= '0;
                            end
                            default:
                            begin
                                if (active_reg != '0)
                                begin
                                    state_reg <= S_LOAD;
                                end
                            end
                        endcase
                    end
                end
                S_CANCEL:
                begin
                    // Compact survivors toward slot zero, one slot a cycle
                    if (rd_reg == active_reg)
                    begin
                        active_reg <= wr_reg;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (rd_slot.handle != cancel_reg)
                        begin
                            wr_reg <= wr_reg + 1'b1;
                        end
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                S_LOAD:
                begin
                    work_reg  <= load_slot;
                    begin_reg <= (load_ended && rd_slot.rep) ? now_reg : begin_eff;
                    from_reg  <= rd_slot.fwd ? rd_slot.sv : rd_slot.ev;
                    to_reg    <= rd_slot.fwd ? rd_slot.ev : rd_slot.sv;
                    keep_reg  <= !load_ended || rd_slot.rep;
                    res_reg   <= load_rsp;
                    if (load_ended)
                    begin
                        // Ended: emit the endpoint, then restart or drop
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        rem_reg     <= {1'b0, el_ext};
                        q_reg       <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // One quotient bit per cycle of elapsed * 2^16 / duration
                    if (rem_dbl >= {1'b0, DW'(work_reg.dur)})
                    begin
                        rem_reg <= rem_dbl - {1'b0, DW'(work_reg.dur)};
                        q_reg   <= {q_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_dbl;
                        q_reg   <= {q_reg[14:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (ease_t'(work_reg.mode) == EASE_LINEAR)
                    begin
                        e_reg     <= {1'b0, q_reg};
                        state_reg <= S_BLEND;
                    end
                    else
                    begin
                        base_reg  <= base_sel;
                        sq_reg    <= base_sel * base_sel;
                        state_reg <= S_CUBE;
                    end
                end
                S_CUBE:
                begin
                    cube_reg  <= 51'(sq_reg) * 51'(base_reg);
                    state_reg <= S_EASE;
                end
                S_EASE:
                begin
                    if (ease_t'(work_reg.mode) != EASE_OUT && !q_reg[15])
                    begin
                        e_reg <= ease_sum[16:0];
                    end
                    else
                    begin
                        e_reg <= ONE_Q16 - ease_sum[16:0];
                    end
                    state_reg <= S_BLEND;
                end
                S_BLEND:
                begin
                    prod_reg <= (51'(to_reg) - 51'(from_reg)) * 51'($signed({1'b0, e_reg}));
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    res_reg.tween_value <= from_reg + blend_q[31:0];
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // Hold until the output register frees up
                    if (out_free)
                    begin
                        rsp_reg <= res_reg;
                        if (!tick_reg || res_reg.last_result)
                        begin
                            if (tick_reg)
                            begin
                                active_reg <= keep_reg ? wr_reg + 1'b1 : wr_reg;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rd_reg <= rd_reg + 1'b1;
                            if (keep_reg)
                            begin
                                wr_reg <= wr_reg + 1'b1;
                            end
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TES_ASSERT_NOW(a_count_bound, 1'b1, active_reg <= CNT_W'(NUM_SLOTS), "active count overflow")
    `TES_ASSERT_NOW(a_handle_nonzero, 1'b1, next_handle_reg != 32'd0, "zero handle issued")
    `TES_ASSERT_NOW(a_full_shape, rsp_valid && rsp_data.table_full, !rsp_data.value_valid && rsp_data.tween_handle == 32'd0, "bad full response")
    `TES_ASSERT_NEXT(a_div_len, state_reg == S_LOAD && el_ext < dur_ext, state_reg == S_DIV, "divide not started")

endmodule

// ===== tb/tween_checker.sv =====
// Checker for the tween easing scheduler: watches both channels, predicts
// responses with its own tween table model and compares them. Depends on tes_pkg.
`timescale 1ns / 1ps

module tween_checker
    import tes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending_count,
    output int   rsp_count,
    output int   finish_count
);
    localparam int SLOTS = 8;

    slot_t       table_q [SLOTS];
    logic [31:0] begin_q [SLOTS];
    int          live_count;
    logic [31:0] handle_next;
    rsp_t        expected_rsps [$];

    assign pending_count = expected_rsps.size();

    function automatic logic [16:0] progress_q16(logic [31:0] el, logic [31:0] dur);
        logic [63:0] num;
        num = {32'd0, el} << 16;
        return 17'(num / dur);
    endfunction

    function automatic logic [16:0] eased(logic [1:0] mode, logic [16:0] t);
        logic [63:0] v;
        if (mode == EASE_LINEAR)
            return t;
        if (mode == EASE_OUT)
        begin
            v = 64'(ONE_Q16 - t);
            return 17'(ONE_Q16 - ((v * v * v + (64'd1 << 31)) >> 32));
        end
        if (t < 17'd32768)
        begin
            v = 64'(t);
            return 17'((v * v * v + (64'd1 << 29)) >> 30);
        end
        v = 64'(2 * (ONE_Q16 - t));
        return 17'(ONE_Q16 - ((v * v * v + (64'd1 << 32)) >> 33));
    endfunction

    function automatic logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [16:0] e);
        logic signed [63:0] diff, prod, q;
        diff = 64'($signed(b)) - 64'($signed(a));
        prod = diff * $signed({47'd0, e});
        // round half up: floor((prod + 32768) / 65536)
        q = (prod + 64'sd32768) >>> 16;
        return 32'(64'($signed(a)) + q);
    endfunction

    task automatic predict_request(req_t r);
        rsp_t        o;
        int          w;
        logic [31:0] el, src, dst;
        slot_t       s;
        o = '0;
        case (op_t'(r.operation))
            OP_START:
            begin
                o.last_result = 1'b1;
                if (live_count >= SLOTS)
                    o.table_full = 1'b1;
                else
                begin
                    s = '0;
                    s.handle = handle_next;
                    s.sv = r.start_value;
                    s.ev = r.end_value;
                    s.dur = (r.duration_time == 0) ? 32'd1 : r.duration_time;
                    s.mode = r.easing_mode;
                    s.rep = r.repeat_enable;
                    s.ping = r.pingpong_enable;
                    s.fwd = 1'b1;
                    table_q[live_count] = s;
                    live_count++;
                    o.tween_handle = handle_next;
                    handle_next = (handle_next == 32'hFFFF_FFFF) ? 32'd1 : handle_next + 1;
                end
                expected_rsps = {expected_rsps, o};
            end
            OP_CANCEL:
            begin
                if (r.cancel_handle != 0)
                begin
                    w = 0;
                    for (int i = 0; i < live_count; i++)
                        if (table_q[i].handle != r.cancel_handle)
                        begin
                            table_q[w] = table_q[i];
                            begin_q[w] = begin_q[i];
                            w++;
                        end
                    live_count = w;
                end
            end
            OP_CLEAR:
                live_count = 0;
            default:
            begin
                w = 0;
                for (int i = 0; i < live_count; i++)
                begin
                    s = table_q[i];
                    o = '0;
                    o.value_valid = 1'b1;
                    o.tween_handle = s.handle;
                    if (!s.started)
                    begin
                        begin_q[i] = r.now_time;
                        s.started = 1'b1;
                    end
                    el = r.now_time - begin_q[i];
                    src = s.fwd ? s.sv : s.ev;
                    dst = s.fwd ? s.ev : s.sv;
                    if (el < s.dur)
                        o.tween_value = mix(src, dst, eased(s.mode, progress_q16(el, s.dur)));
                    else
                    begin
                        o.tween_value = dst;
                        if (s.rep)
                        begin
                            if (s.ping)
                                s.fwd = !s.fwd;
                            begin_q[i] = r.now_time;
                        end
                        else
                            o.finished = 1'b1;
                    end
                    o.last_result = (i == live_count - 1);
                    expected_rsps = {expected_rsps, o};
                    if (!o.finished)
                    begin
                        table_q[w] = s;
                        begin_q[w] = begin_q[i];
                        w++;
                    end
                end
                live_count = w;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            live_count = 0;
            handle_next = 32'd1;
            fail_count = 0;
            rsp_count = 0;
            finish_count = 0;
            expected_rsps.delete();
        end
        else
        begin
            // Check the response first: a request accepted this edge cannot
            // already have produced one.
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (rsp_data.finished)
                    finish_count++;
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (e !== rsp_data)
                    begin
                        $display("%0t: mismatch exp h=%h v=%h vv=%b fin=%b full=%b last=%b",
                                 $time, e.tween_handle, e.tween_value, e.value_valid,
                                 e.finished, e.table_full, e.last_result);
                        $display("%0t:          act h=%h v=%h vv=%b fin=%b full=%b last=%b",
                                 $time, rsp_data.tween_handle, rsp_data.tween_value,
                                 rsp_data.value_valid, rsp_data.finished,
                                 rsp_data.table_full, rsp_data.last_result);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                predict_request(req_data);
        end
    end
endmodule

// ===== tb/tb.sv =====
// Top of the tween easing scheduler testbench: clock, reset, request stimulus,
// response stalls and verdict. Depends on tes_pkg, tween_checker and the block.
`timescale 1ns / 1ps

module tb;
    import tes_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    int fail_count, pending_count, rsp_count, finish_count;
    int cycle_count = 0;
    int req_count = 0;
    logic [31:0] clock_us = 32'd0;  // running time base for tick requests
    logic [31:0] last_handle = 32'd0;

    always #4 clk = ~clk;

    tween_easing_scheduler_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    tween_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .rsp_count     (rsp_count),
        .finish_count  (finish_count)
    );

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls at random early in each stimulus period, then runs stall-free.
    always @(posedge clk)
    begin
        if ((cycle_count % 4000) > 2000)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, pending_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Present one request and hold it until the block accepts it. Valid drops
    // only when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(req_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        req_count++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 20)) - 10) << 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t start_req(logic [31:0] dur);
        req_t r;
        r = '0;
        r.operation = OP_START;
        r.start_value = rand_value();
        r.end_value = rand_value();
        r.duration_time = dur;
        r.easing_mode = 2'($urandom_range(0, 3));
        r.repeat_enable = 1'($urandom_range(0, 1));
        r.pingpong_enable = 1'($urandom_range(0, 1));
        r.now_time = $urandom();
        r.cancel_handle = $urandom();
        return r;
    endfunction

    function automatic req_t tick_req(logic [31:0] at);
        req_t r;
        r = '0;
        r.operation = OP_TICK;
        r.now_time = at;
        r.start_value = $urandom();
        r.duration_time = $urandom();
        return r;
    endfunction

    function automatic req_t ctl_req(op_t op, logic [31:0] h);
        req_t r;
        r = '0;
        r.operation = op;
        r.cancel_handle = h;
        return r;
    endfunction

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        int   n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, every easing at the value extremes, zero and
        // maximum duration, wrapping time, full table, cancel and clear.
        send_request(tick_req(32'd5));
        for (int m = 0; m < 4; m++)
        begin
            r = start_req(m == 0 ? 32'd0 : 32'd1000);
            r.easing_mode = 2'(m);
            r.start_value = 32'h8000_0000;
            r.end_value = 32'h7FFF_FFFF;
            r.repeat_enable = (m >= 2);
            r.pingpong_enable = (m == 3);
            send_request(r);
        end
        r = start_req(32'hFFFF_FFFF);
        r.start_value = 32'h7FFF_FFFF;
        r.end_value = 32'h8000_0000;
        send_request(r);
        send_request(start_req(32'd400));
        send_request(start_req(32'd50));
        send_request(start_req(32'd700));
        send_request(start_req(32'd10));    // table full here
        send_request(tick_req(32'hFFFF_FF00));
        send_request(tick_req(32'h0000_0100)); // elapsed across the wrap
        send_request(tick_req(32'h0000_0200));
        send_request(tick_req(32'h0000_0400));
        send_request(ctl_req(OP_CANCEL, 32'd0));
        send_request(ctl_req(OP_CANCEL, 32'd3));
        send_request(ctl_req(OP_CANCEL, 32'd999));
        send_request(tick_req(32'h0000_0900));
        send_request(ctl_req(OP_CLEAR, $urandom()));
        send_request(tick_req(32'h0000_0A00));
        drain();    // hold off until every expected response is in

        // Random: mostly start/tick sequences with advancing time.
        clock_us = 32'hFFF0_0000;
        n = 0;
        while (n < 450)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                begin
                    r = start_req($urandom_range(0, 9) == 0 ? $urandom()
                                  : 32'($urandom_range(0, 3000)));
                    send_request(r);
                    last_handle = last_handle + 1;
                end
                6:
                    send_request(ctl_req(OP_CANCEL, $urandom_range(0, 3) == 0 ? $urandom()
                                 : last_handle - 32'($urandom_range(0, 6))));
                7:
                    if ($urandom_range(0, 3) == 0)
                        send_request(ctl_req(OP_CLEAR, $urandom()));
                    else
                        send_request(tick_req(clock_us));
                default:
                begin
                    clock_us = clock_us + 32'($urandom_range(0, 800));
                    send_request(tick_req($urandom_range(0, 30) == 0 ? $urandom()
                                          : clock_us));
                end
            endcase
            n++;
        end

        drain();
        $display("tb: %0d requests sent, %0d responses checked, %0d tweens finished",
                 req_count, rsp_count, finish_count);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
